/* hdl/shep_pkg.sv */
// Shared types, codes and helpers of the slice header Exp-Golomb parser.
package shep_pkg;

  localparam int UE_W  = 32;
  localparam int FIX_W = 16;
  localparam int CFG_W = 5;
  localparam int CNT_W = 6;

  localparam logic [CFG_W-1:0] WIDTH_CAP       = 5'd16;
  localparam logic [CFG_W-1:0] FRAME_BITS_RST  = 5'd4;
  localparam logic [CFG_W-1:0] POC_BITS_RST    = 5'd6;

  typedef enum logic [2:0] {
    STEP_FIRST_MB,
    STEP_SLICE_KIND,
    STEP_PARAM_SET,
    STEP_FRAME_NUM,
    STEP_POC_LSB,
    STEP_DONE
  } step_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_ZERO_RUN
  } status_t;

  typedef enum logic {
    REG_FRAME_NUM_BITS,
    REG_POC_LSB_BITS
  } cfg_reg_t;

  typedef struct packed {
    step_t             field_step;
    logic              in_suffix;
    logic [CNT_W-1:0]  zero_run;
    logic [CNT_W-1:0]  bits_left;
    logic [UE_W-1:0]   acc;
    logic [UE_W-1:0]   held_first_mb;
    logic [UE_W-1:0]   held_slice_kind;
    logic [UE_W-1:0]   held_param_set;
    logic [FIX_W-1:0]  held_frame_number;
    logic              finished;
  } parse_st_t;

  // Result request raised inside a byte by one of the bit cells.
  typedef struct packed {
    logic              valid;
    logic [FIX_W-1:0]  poc;
    status_t           status;
  } hit_t;

  typedef struct packed {
    status_t           status;
    logic [FIX_W-1:0]  poc_lsb;
    logic [FIX_W-1:0]  frame_number;
    logic [UE_W-1:0]   param_set_id;
    logic [UE_W-1:0]   slice_kind;
    logic [UE_W-1:0]   first_mb;
  } result_t;

  function automatic logic [CNT_W-1:0] eff_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] capped;
    capped = (w > WIDTH_CAP) ? WIDTH_CAP : w;
    return {1'b0, capped};
  endfunction

  function automatic parse_st_t clear_state();
    parse_st_t s;
    s = '0;
    s.field_step = STEP_FIRST_MB;
    return s;
  endfunction

endpackage

/* hdl/shep_bit_cell.sv */
// One bit step of the header parser: consumes a single header bit.
module shep_bit_cell
  import shep_pkg::*;
(
  input  parse_st_t        st_i,
  input  hit_t             hit_i,
  input  logic             hdr_bit,
  input  logic [CNT_W-1:0] frame_w,
  input  logic [CNT_W-1:0] poc_w,
  output parse_st_t        st_o,
  output hit_t             hit_o
);

  always_comb begin
    parse_st_t        s;
    hit_t             h;
    logic             ue_done;
    logic             settle_chk;
    logic [UE_W-1:0]  ue_v;
    logic [UE_W-1:0]  mask;
    logic [UE_W-1:0]  acc_sh;
    logic [CNT_W-1:0] zr_inc;
    logic [CNT_W-1:0] bl_dec;

    s          = st_i;
    h          = hit_i;
    ue_done    = 1'b0;
    settle_chk = 1'b0;
    ue_v       = '0;
    zr_inc     = st_i.zero_run + 6'd1;
    bl_dec     = st_i.bits_left - 6'd1;
    acc_sh     = {st_i.acc[UE_W-2:0], hdr_bit};
    mask       = (32'd1 << st_i.zero_run[4:0]) - 32'd1;

    if (!st_i.finished) begin
      unique case (st_i.field_step)
        STEP_FIRST_MB, STEP_SLICE_KIND, STEP_PARAM_SET: begin
          if (!st_i.in_suffix) begin
            if (!hdr_bit) begin
              s.zero_run = zr_inc;
              if (zr_inc[CNT_W-1]) begin
                // prefix hit 32 zeros: give up on this header
                h.valid      = 1'b1;
                h.poc        = '0;
                h.status     = ST_ZERO_RUN;
                s.finished   = 1'b1;
                s.field_step = STEP_DONE;
              end
            end else if (st_i.zero_run == '0) begin
              ue_done = 1'b1;
              ue_v    = '0;
            end else begin
              s.in_suffix = 1'b1;
              s.bits_left = st_i.zero_run;
              s.acc       = '0;
            end
          end else begin
            s.acc       = acc_sh;
            s.bits_left = bl_dec;
            if (bl_dec == '0) begin
              ue_done = 1'b1;
              ue_v    = mask + acc_sh;
            end
          end
        end
        STEP_FRAME_NUM, STEP_POC_LSB: begin
          s.acc = {16'd0, st_i.acc[FIX_W-2:0], hdr_bit};
          if (st_i.bits_left != '0) s.bits_left = bl_dec;
          settle_chk = 1'b1;
        end
        default: begin
          s.finished = 1'b1;
        end
      endcase

      if (ue_done) begin
        s.zero_run  = '0;
        s.in_suffix = 1'b0;
        s.acc       = '0;
        settle_chk  = 1'b1;
        unique case (st_i.field_step)
          STEP_FIRST_MB: begin
            s.held_first_mb = ue_v;
            s.field_step    = STEP_SLICE_KIND;
          end
          STEP_SLICE_KIND: begin
            s.held_slice_kind = ue_v;
            s.field_step      = STEP_PARAM_SET;
          end
          default: begin
            s.held_param_set = ue_v;
            s.field_step     = STEP_FRAME_NUM;
            s.bits_left      = frame_w;
          end
        endcase
      end

      // Close fixed-width fields whose bit count ran out.
      if (settle_chk) begin
        if (s.field_step == STEP_FRAME_NUM && s.bits_left == '0) begin
          s.held_frame_number = s.acc[FIX_W-1:0];
          s.field_step        = STEP_POC_LSB;
          s.bits_left         = poc_w;
          s.acc               = '0;
        end
        if (s.field_step == STEP_POC_LSB && s.bits_left == '0) begin
          h.valid      = 1'b1;
          h.poc        = s.acc[FIX_W-1:0];
          h.status     = ST_OK;
          s.finished   = 1'b1;
          s.field_step = STEP_DONE;
        end
      end
    end

    st_o  = s;
    hit_o = h;
  end

endmodule

/* hdl/shep_parse.sv */
// Parse state register with the eight-bit-cell chain that advances it per byte.
module shep_parse
  import shep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       hdr_byte,
  input  logic             hdr_last,
  input  logic [CFG_W-1:0] frame_bits,
  input  logic [CFG_W-1:0] poc_bits,
  output logic             res_valid,
  output result_t          res,
  output logic             fresh
);

  parse_st_t        state_r;
  parse_st_t        state_nxt;
  parse_st_t        chain_st  [0:8];
  hit_t             chain_hit [0:8];
  logic [CNT_W-1:0] frame_w;
  logic [CNT_W-1:0] poc_w;

  assign frame_w      = eff_width(frame_bits);
  assign poc_w        = eff_width(poc_bits);
  assign chain_st[0]  = state_r;
  assign chain_hit[0] = '0;

  for (genvar g = 0; g < 8; g++) begin : g_cell
    shep_bit_cell u_cell (
      .st_i    (chain_st[g]),
      .hit_i   (chain_hit[g]),
      .hdr_bit (hdr_byte[7-g]),
      .frame_w (frame_w),
      .poc_w   (poc_w),
      .st_o    (chain_st[g+1]),
      .hit_o   (chain_hit[g+1])
    );
  end

  always_comb begin
    res.first_mb     = chain_st[8].held_first_mb;
    res.slice_kind   = chain_st[8].held_slice_kind;
    res.param_set_id = chain_st[8].held_param_set;
    res.frame_number = chain_st[8].held_frame_number;
    if (chain_hit[8].valid) begin
      res.poc_lsb = chain_hit[8].poc;
      res.status  = chain_hit[8].status;
    end else begin
      res.poc_lsb = '0;
      res.status  = ST_TRUNC;
    end
    res_valid = chain_hit[8].valid || (hdr_last && !chain_st[8].finished);
    state_nxt = hdr_last ? clear_state() : chain_st[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clear_state();
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  assign fresh = (state_r == clear_state());

endmodule

/* hdl/slice_header_expgolomb_parser_unit.sv */
// Top level of the slice header Exp-Golomb parser: stream ports, config, in/out registers.
// Path: a byte goes from the input register through one pass of the bit-cell chain,
// and any result it completes is loaded into the output register on out_*.
// Throughput: one byte per clock unless stalled; eight bit cells finish a byte per cycle.
// Stalls: a result waiting on out_tready holds the parser; in_tready drops if a byte is stuck.
// Reset (rst_n low, synchronous): parse state clears, widths go to 4 and 6, registers empty.
module slice_header_expgolomb_parser_unit
  import shep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // header byte request
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // end_of_buffer
  // result request
  output logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] first_mb, [63:32] slice_kind, [95:64] param_set_id,
  // [111:96] frame_number, [127:112] poc_lsb
  output logic [127:0]     out_tdata,
  output logic [1:0]       out_tuser,  // [1:0] status
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic             out_valid_r;
  result_t          out_data_r;
  logic [CFG_W-1:0] frame_bits_r;
  logic [CFG_W-1:0] poc_bits_r;
  logic             fire;
  logic             res_valid;
  result_t          res;
  logic             parse_fresh;

  // Advance the parser whenever a byte is held and the result slot can take a result.
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  // Width registers; the user is to write them only between headers (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r <= FRAME_BITS_RST;
      poc_bits_r   <= POC_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_NUM_BITS: frame_bits_r <= cfg_data;
        REG_POC_LSB_BITS:   poc_bits_r   <= cfg_data;
      endcase
    end
  end

  // Input register: hold one byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  shep_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire),
    .hdr_byte   (in_byte_r),
    .hdr_last   (in_last_r),
    .frame_bits (frame_bits_r),
    .poc_bits   (poc_bits_r),
    .res_valid  (res_valid),
    .res        (res),
    .fresh      (parse_fresh)
  );

  // Output register: load a new result, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.poc_lsb, out_data_r.frame_number,
                       out_data_r.param_set_id, out_data_r.slice_kind,
                       out_data_r.first_mb};
  assign out_tuser  = out_data_r.status;

`ifndef NO_ASSERTIONS
  // An aborted header never carries a POC LSB value.
  a_abort_poc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |-> (out_data_r.poc_lsb == '0))
    else $error("aborted result carries nonzero poc_lsb");

  // A zero-run abort happens before the frame number is ever read.
  a_zero_run_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_ZERO_RUN) |-> (out_data_r.frame_number == '0))
    else $error("zero-run result carries a frame number");

  // A new result only appears from a parser step that produced one.
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && res_valid))
    else $error("result appeared without a producing step");

  // The parser is back at the start of a header after the last byte of a buffer.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_r) |=> parse_fresh)
    else $error("parse state not cleared after end of buffer");
`endif

endmodule

/* dv/slice_header_expgolomb_parser_unit_checker.sv */
// Checker for the slice header Exp-Golomb parser: predicts header results and compares them.
module slice_header_expgolomb_parser_unit_checker
  import shep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // end_of_buffer
  input  logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] first_mb, [63:32] slice_kind, [95:64] param_set_id,
  // [111:96] frame_number, [127:112] poc_lsb
  input  logic [127:0]     out_tdata,
  input  logic [1:0]       out_tuser,  // [1:0] status
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               headers_pending,
  output int               ok_results,
  output int               trunc_results,
  output int               zero_run_results
);

  // Programmed field widths.
  logic [CFG_W-1:0] frame_bits_reg;
  logic [CFG_W-1:0] poc_bits_reg;

  // Parse position inside the current header buffer.
  step_t            step;
  logic             in_suffix;
  logic [CNT_W-1:0] zeros;
  logic [CNT_W-1:0] bits_left;
  logic [UE_W-1:0]  acc;
  logic [UE_W-1:0]  hold_mb;
  logic [UE_W-1:0]  hold_kind;
  logic [UE_W-1:0]  hold_pps;
  logic [FIX_W-1:0] hold_frame;
  logic             header_done;

  result_t expected_headers[$];
  result_t got;
  result_t want;
  int      fails  = 0;
  int      n_ok   = 0;
  int      n_trunc = 0;
  int      n_zero = 0;

  function automatic logic [CNT_W-1:0] capped_width(input logic [CFG_W-1:0] w);
    return (w > 5'd16) ? 6'd16 : {1'b0, w};
  endfunction

  task automatic restart_header();
    step        = STEP_FIRST_MB;
    in_suffix   = 1'b0;
    zeros       = '0;
    bits_left   = '0;
    acc         = '0;
    hold_mb     = '0;
    hold_kind   = '0;
    hold_pps    = '0;
    hold_frame  = '0;
    header_done = 1'b0;
  endtask

  task automatic post_header(input logic [FIX_W-1:0] poc, input status_t status);
    result_t r;
    r.first_mb     = hold_mb;
    r.slice_kind   = hold_kind;
    r.param_set_id = hold_pps;
    r.frame_number = hold_frame;
    r.poc_lsb      = poc;
    r.status       = status;
    expected_headers.push_back(r);
    header_done = 1'b1;
    step        = STEP_DONE;
  endtask

  // Close fixed-width fields whose bit budget is spent; a zero width closes at once.
  task automatic close_fixed_fields();
    while (!header_done && (step == STEP_FRAME_NUM || step == STEP_POC_LSB) &&
           bits_left == '0) begin
      if (step == STEP_FRAME_NUM) begin
        hold_frame = acc[FIX_W-1:0];
        step       = STEP_POC_LSB;
        bits_left  = capped_width(poc_bits_reg);
        acc        = '0;
      end else begin
        post_header(acc[FIX_W-1:0], ST_OK);
      end
    end
  endtask

  task automatic take_ue(input logic [UE_W-1:0] v);
    case (step)
      STEP_FIRST_MB:   hold_mb   = v;
      STEP_SLICE_KIND: hold_kind = v;
      default:         hold_pps  = v;
    endcase
    step      = step_t'(step + 3'd1);
    zeros     = '0;
    in_suffix = 1'b0;
    acc       = '0;
    if (step == STEP_FRAME_NUM) bits_left = capped_width(frame_bits_reg);
  endtask

  // Walk one header byte MSB first and queue the result it completes, if any.
  task automatic decode_header_byte(input logic [7:0] b, input logic eob);
    logic bitv;
    for (int i = 7; i >= 0; i--) begin
      if (!header_done) begin
        bitv = b[i];
        if (step <= STEP_PARAM_SET) begin
          if (!in_suffix) begin
            if (!bitv) begin
              zeros = zeros + 6'd1;
              if (zeros >= 6'd32) post_header('0, ST_ZERO_RUN);
            end else if (zeros == '0) begin
              take_ue('0);
              close_fixed_fields();
            end else begin
              in_suffix = 1'b1;
              bits_left = zeros;
              acc       = '0;
            end
          end else begin
            acc       = {acc[UE_W-2:0], bitv};
            bits_left = bits_left - 6'd1;
            if (bits_left == '0) begin
              take_ue(((32'd1 << zeros) - 32'd1) + acc);
              close_fixed_fields();
            end
          end
        end else if (step == STEP_FRAME_NUM || step == STEP_POC_LSB) begin
          acc = {16'd0, acc[FIX_W-2:0], bitv};
          if (bits_left != '0) bits_left = bits_left - 6'd1;
          close_fixed_fields();
        end else begin
          header_done = 1'b1;
        end
      end
    end
    if (eob) begin
      if (!header_done) post_header('0, ST_TRUNC);
      restart_header();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_reg = FRAME_BITS_RST;
      poc_bits_reg   = POC_BITS_RST;
      restart_header();
      expected_headers.delete();
    end else begin
      // Results first: a byte taken at this edge cannot already have its result out.
      if (out_tvalid && out_tready) begin
        got = result_t'({out_tuser, out_tdata});
        if (expected_headers.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, expected none, actual status %0d",
                   $time, got.status);
        end else begin
          want = expected_headers[0];
          expected_headers.delete(0);
          check_field("first_mb", want.first_mb, got.first_mb);
          check_field("slice_kind", want.slice_kind, got.slice_kind);
          check_field("param_set_id", want.param_set_id, got.param_set_id);
          check_field("frame_number", 32'(want.frame_number), 32'(got.frame_number));
          check_field("poc_lsb", 32'(want.poc_lsb), 32'(got.poc_lsb));
          check_field("status", 32'(want.status), 32'(got.status));
          case (want.status)
            ST_OK:    n_ok++;
            ST_TRUNC: n_trunc++;
            default:  n_zero++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_NUM_BITS) frame_bits_reg = cfg_data;
        else poc_bits_reg = cfg_data;
      end
      if (in_tvalid && in_tready) decode_header_byte(in_tdata, in_tlast);
    end
    headers_pending  <= expected_headers.size();
    fail_count       <= fails;
    ok_results       <= n_ok;
    trunc_results    <= n_trunc;
    zero_run_results <= n_zero;
  end

endmodule

/* dv/slice_header_expgolomb_parser_unit_test.sv */
// Testbench top for the slice header Exp-Golomb parser: stimulus, pacing and verdict.
module slice_header_expgolomb_parser_unit_test;
  import shep_pkg::*;

  localparam int TOTAL_BYTES   = 1140;  // directed bytes plus the random stream
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 4000;  // cycles with no request moving before giving up
  localparam int SETTLE_CYCLES = 6;     // covers the input and output registers with margin

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [127:0]     out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic             cfg_index  = REG_FRAME_NUM_BITS;
  logic [CFG_W-1:0] cfg_data   = '0;

  int fail_count;
  int headers_pending;
  int ok_results;
  int trunc_results;
  int zero_run_results;

  // Header under construction: bits first, then packed bytes ready to send.
  logic       bit_q[$];
  logic [7:0] byte_q[$];

  // Our copy of the width registers, used to shape well-formed headers.
  logic [CFG_W-1:0] frame_reg = FRAME_BITS_RST;
  logic [CFG_W-1:0] poc_reg   = POC_BITS_RST;

  int bytes_sent  = 0;
  int cfg_writes  = 0;
  int burst_left  = 8;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int ready_mode  = 0;
  int ready_epoch = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slice_header_expgolomb_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  slice_header_expgolomb_parser_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .headers_pending  (headers_pending),
    .ok_results       (ok_results),
    .trunc_results    (trunc_results),
    .zero_run_results (zero_run_results)
  );

  // Receiver: change stall style every epoch; a hold-off asked by the stimulus
  // overrides it and is counted down here, not in the sender.
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (ready_epoch == 0) begin
      ready_mode  = $urandom_range(0, 2);
      ready_epoch = $urandom_range(20, 150);
      ready_pat   = 16'($urandom) | 16'h0001;
    end
    ready_epoch = ready_epoch - 1;
    ready_pat   = {ready_pat[14:0], ready_pat[15]};
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 9) < 7);
        default: out_tready <= ready_pat[0];
      endcase
    end
  end

  // Watchdog: give up when no request of any channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("slice_header_expgolomb_parser_unit_test: errors");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] live_width(input logic [CFG_W-1:0] w);
    return (w > 5'd16) ? 5'd16 : w;
  endfunction

  // Mostly short codes, some long ones and now and then the largest legal value.
  function automatic logic [31:0] pick_ue();
    logic [31:0] v;
    case ($urandom_range(0, 19))
      0:       v = 32'hFFFF_FFFE;
      1, 2, 3: begin
        v = $urandom >> $urandom_range(0, 31);
        if (v == 32'hFFFF_FFFF) v = 32'hFFFF_FFFE;
      end
      4, 5, 6, 7, 8, 9: v = $urandom_range(0, 255);
      default: v = $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  function automatic logic [32:0] pick_fixed();
    return ($urandom_range(0, 3) == 0) ? '1 : 33'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'd31;
      3:       return 5'($urandom_range(17, 30));
      default: return 5'($urandom_range(1, 12));
    endcase
  endfunction

  // Offer one header byte and hold it until taken; end a burst with a random gap.
  task automatic push_byte(input logic [7:0] b, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken,
  // then let the pipe empty of bytes that produce nothing.
  task automatic wait_for_headers();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (headers_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_NUM_BITS) frame_reg = val;
    else poc_reg = val;
    cfg_writes++;
  endtask

  // Write one or both widths back to back, then drop the request.
  task automatic write_widths(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] pw,
                              input logic do_frame, input logic do_poc);
    if (do_frame) write_reg(REG_FRAME_NUM_BITS, fw);
    if (do_poc) write_reg(REG_POC_LSB_BITS, pw);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure();
    logic do_frame;
    do_frame = 1'($urandom_range(0, 1));
    wait_for_headers();
    write_widths(pick_width(), pick_width(), do_frame, !do_frame || $urandom_range(0, 1));
  endtask

  task automatic add_bits(input logic [32:0] val, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) bit_q.push_back(val[i]);
  endtask

  // Exp-Golomb: N zeros, then value+1 in N+1 bits.
  task automatic add_ue(input logic [31:0] v);
    logic [32:0] code;
    int          lead;
    code = {1'b0, v} + 33'd1;
    lead = 0;
    for (int i = 0; i < 33; i++) if (code[i]) lead = i;
    add_bits('0, lead);
    add_bits(code, lead + 1);
  endtask

  task automatic add_header(input logic [31:0] mb, input logic [31:0] kind,
                            input logic [31:0] pps, input logic [32:0] fnum,
                            input logic [32:0] poc);
    add_ue(mb);
    add_ue(kind);
    add_ue(pps);
    add_bits(fnum, int'(live_width(frame_reg)));
    add_bits(poc, int'(live_width(poc_reg)));
  endtask

  // Pad to a whole byte with random bits and move the bits into the byte queue.
  task automatic pack_bits();
    logic [7:0] b;
    while (bit_q.size() % 8 != 0) bit_q.push_back(1'($urandom_range(0, 1)));
    while (bit_q.size() != 0) begin
      for (int i = 7; i >= 0; i--) begin
        b[i] = bit_q[0];
        bit_q.delete(0);
      end
      byte_q.push_back(b);
    end
  endtask

  task automatic add_trailing(input int n);
    repeat (n) byte_q.push_back(8'($urandom));
  endtask

  task automatic send_bytes(input int n, input logic close);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = byte_q[0];
      byte_q.delete(0);
      push_byte(b, close && (i == n - 1));
    end
  endtask

  initial begin : stimulus
    int kind;
    int cut;
    int next_cfg;
    int next_hold;
    int holds_given;

    holds_given = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset widths. Three one-bit codes, fixed fields all ones; the last field
    // closes inside the closing byte, so only the normal result must come.
    add_header(0, 0, 0, '1, '1);
    pack_bits();
    send_bytes(byte_q.size(), 1'b1);

    // Largest legal code first, zero fixed fields.
    add_header(32'hFFFF_FFFE, 5, 1, '0, '0);
    pack_bits();
    send_bytes(byte_q.size(), 1'b1);

    // Thirty-two zeros: code error right on the closing byte.
    repeat (4) byte_q.push_back(8'h00);
    send_bytes(4, 1'b1);

    // Buffer ends inside the POC field: truncated, frame number kept.
    push_byte(8'hFF, 1'b1);

    // Zero widths: the header ends mid-byte, the rest of the buffer is dropped.
    wait_for_headers();
    write_widths(5'd0, 5'd0, 1'b1, 1'b1);
    push_byte(8'hE5, 1'b0);
    push_byte(8'($urandom), 1'b1);

    // Widths above the cap, then change widths while the frame number is open:
    // the frame keeps its width, the POC field picks up the new one.
    wait_for_headers();
    write_widths(5'd31, 5'd16, 1'b1, 1'b1);
    add_header(0, 0, 0, '1, '1);
    pack_bits();
    send_bytes(1, 1'b0);
    wait_for_headers();
    write_widths(5'd0, 5'd4, 1'b1, 1'b1);
    send_bytes(byte_q.size(), 1'b1);

    // Random stream: mostly well-formed headers with random content, the rest
    // truncated buffers, zero runs and plain noise.
    reconfigure();
    next_cfg  = bytes_sent + $urandom_range(80, 160);
    next_hold = bytes_sent + 350;
    while (bytes_sent < TOTAL_BYTES) begin
      // Ask for a long receiver hold-off while headers keep coming.
      if (holds_given < 2 && bytes_sent >= next_hold) begin
        hold_asks++;
        holds_given++;
        next_hold += 400;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_header(pick_ue(), pick_ue(), pick_ue(), pick_fixed(), pick_fixed());
        pack_bits();
        add_trailing($urandom_range(0, 2));
        // Sometimes land a width change halfway through this header.
        if (bytes_sent >= next_cfg && byte_q.size() > 1 && $urandom_range(0, 2) == 0) begin
          cut = $urandom_range(1, byte_q.size() - 1);
          send_bytes(cut, 1'b0);
          reconfigure();
          next_cfg = bytes_sent + $urandom_range(80, 160);
        end
        send_bytes(byte_q.size(), 1'b1);
      end else if (kind < 80) begin
        add_header(pick_ue(), pick_ue(), pick_ue(), pick_fixed(), pick_fixed());
        pack_bits();
        cut = $urandom_range(1, byte_q.size());
        send_bytes(cut, 1'b1);
        byte_q.delete();
      end else if (kind < 90) begin
        repeat ($urandom_range(0, 2)) add_ue($urandom_range(0, 3));
        add_bits('0, $urandom_range(32, 40));
        pack_bits();
        add_trailing($urandom_range(0, 2));
        send_bytes(byte_q.size(), 1'b1);
      end else begin
        // Noise; leave the buffer open now and then so it runs into the next one.
        add_trailing($urandom_range(1, 6));
        send_bytes(byte_q.size(), $urandom_range(0, 3) != 0);
      end
      if (bytes_sent >= next_cfg) begin
        reconfigure();
        next_cfg = bytes_sent + $urandom_range(80, 160);
      end
    end

    wait_for_headers();
    $display("covered %0d header bytes across width settings, %0d register writes",
             bytes_sent, cfg_writes);
    $display("results seen: %0d complete, %0d cut short, %0d zero-run errors",
             ok_results, trunc_results, zero_run_results);
    if (fail_count == 0 && headers_pending == 0) begin
      $display("slice_header_expgolomb_parser_unit_test: clean");
    end else begin
      $display("slice_header_expgolomb_parser_unit_test: errors");
    end
    $finish;
  end

endmodule
